[src/cmws_pkg.sv]
// Shared types, register map and helper functions for the colour math stage.
// No dependencies; used by color_math_window_stage_core.
`timescale 1ns / 1ps
`default_nettype none

package cmws_pkg;

    // Register byte addresses on the configuration port
    localparam int unsigned AddrWidth = 5;
    localparam logic [AddrWidth-1:0] ADDR_WINDOW_BOUNDS = 5'd0;
    localparam logic [AddrWidth-1:0] ADDR_COLOR_WIN_CTRL = 5'd4;
    localparam logic [AddrWidth-1:0] ADDR_MATH_CTRL = 5'd8;
    localparam logic [AddrWidth-1:0] ADDR_FIXED_COLOR = 5'd12;
    localparam logic [AddrWidth-1:0] ADDR_BRIGHTNESS = 5'd16;
    localparam logic [AddrWidth-1:0] ADDR_FORCED_BLANK = 5'd20;

    // Source layer codes
    localparam logic [2:0] SRC_BACKDROP = 3'd5;
    localparam logic [2:0] SRC_LAST_MATH = 3'd5;

    // Window combine codes
    localparam logic [1:0] COMB_OR = 2'd0;
    localparam logic [1:0] COMB_AND = 2'd1;
    localparam logic [1:0] COMB_XOR = 2'd2;
    localparam logic [1:0] COMB_XNOR = 2'd3;

    // Clip / prevent-math modes
    localparam logic [1:0] MODE_NEVER = 2'd0;
    localparam logic [1:0] MODE_OUTSIDE = 2'd1;
    localparam logic [1:0] MODE_INSIDE = 2'd2;
    localparam logic [1:0] MODE_ALWAYS = 2'd3;

    // Reciprocal of 15 in Q15, exact for products below 4096
    localparam logic [11:0] RECIP_15 = 12'd2185;

    typedef struct packed {
        logic [4:0] blue;
        logic [4:0] green;
        logic [4:0] red;
    } rgb5_t;

    typedef struct packed {
        rgb5_t      sub_color;
        rgb5_t      main_color;
        logic [7:0] pixel_x;
    } pix_data_t;

    typedef struct packed {
        logic [2:0] sub_source;
        logic [2:0] main_source;
    } pix_user_t;

    typedef struct packed {
        logic       half;
        logic       subtract;
        logic       use_sub;
        logic [5:0] layer_mask;
        logic [1:0] prevent_mode;
        logic [1:0] clip_mode;
    } math_ctrl_t;

    function automatic logic in_range(input logic [7:0] x, input logic [7:0] lo,
                                      input logic [7:0] hi);
        return (x >= lo) && (x <= hi);
    endfunction

    function automatic logic mode_hits(input logic [1:0] mode, input logic win);
        return (mode == MODE_ALWAYS) || ((mode == MODE_INSIDE) && win)
            || ((mode == MODE_OUTSIDE) && !win);
    endfunction

    // One component: add or subtract, floor at 0, optional halve, clamp to 31
    function automatic logic [4:0] mix_comp(input logic [4:0] m, input logic [4:0] op,
                                            input logic subtract, input logic halve);
        logic [5:0] v;
        logic [5:0] w;
        v = subtract ? (({1'b0, m} < {1'b0, op}) ? 6'd0 : ({1'b0, m} - {1'b0, op}))
                     : ({1'b0, m} + {1'b0, op});
        w = halve ? {1'b0, v[5:1]} : v;
        return w[5] ? 5'd31 : w[4:0];
    endfunction

    function automatic logic [7:0] expand5(input logic [4:0] c);
        return {c, c[4:2]};
    endfunction

endpackage

`default_nettype wire

[src/color_math_window_stage_core.sv]
// Colour window, clip, colour math, 5-to-8 bit expansion and brightness scaling.
// Depends on cmws_pkg.
//
//  port group    | dir | handshake           | payload
//  s_axis_*      | in  | tvalid/tready       | tdata: pixel + colours, tuser: sources
//  m_axis_*      | out | tvalid/tready       | tdata: out rgb, 8 bits each
//  APB (p*)      | in  | psel/penable/pready | 32-bit registers at 4*index
//
// Three register stages: input register, brightness product, divided result.
// One pixel per cycle sustained while m_axis_tready is high.
// Each stage moves whenever its successor is empty or moving, so a stall on
// m_axis_tready backs up stage by stage without losing requests.
// Synchronous aresetn clears valid flags and config, sets brightness 15, blank on.
`timescale 1ns / 1ps
`default_nettype none

module color_math_window_stage_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [7:0] pixel_x, [12:8] main_red, [17:13] main_green, [22:18] main_blue,
    // [27:23] sub_red, [32:28] sub_green, [37:33] sub_blue, [39:38] zero
    input  wire logic [39:0] s_axis_tdata,
    // [2:0] main_source, [5:3] sub_source
    input  wire logic [5:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] out_red, [15:8] out_green, [23:16] out_blue
    output logic [23:0]      m_axis_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [cmws_pkg::AddrWidth-1:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // ---------------- configuration ----------------
    logic [31:0]          win_bounds_reg;
    logic [5:0]           win_ctrl_reg;
    cmws_pkg::math_ctrl_t math_ctrl_reg;
    cmws_pkg::rgb5_t      fixed_color_reg;
    logic [3:0]           brightness_reg;
    logic                 forced_blank_reg;
    logic                 cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_bounds_reg   <= '0;
            win_ctrl_reg     <= '0;
            math_ctrl_reg    <= '0;
            fixed_color_reg  <= '0;
            brightness_reg   <= 4'd15;
            forced_blank_reg <= 1'b1;
        end else if (cfg_wr) begin
            unique case (paddr)
                cmws_pkg::ADDR_WINDOW_BOUNDS:  win_bounds_reg   <= pwdata;
                cmws_pkg::ADDR_COLOR_WIN_CTRL: win_ctrl_reg     <= pwdata[5:0];
                cmws_pkg::ADDR_MATH_CTRL:      math_ctrl_reg    <= pwdata[12:0];
                cmws_pkg::ADDR_FIXED_COLOR:    fixed_color_reg  <= pwdata[14:0];
                cmws_pkg::ADDR_BRIGHTNESS:     brightness_reg   <= pwdata[3:0];
                cmws_pkg::ADDR_FORCED_BLANK:   forced_blank_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            cmws_pkg::ADDR_WINDOW_BOUNDS:  prdata = win_bounds_reg;
            cmws_pkg::ADDR_COLOR_WIN_CTRL: prdata = {26'd0, win_ctrl_reg};
            cmws_pkg::ADDR_MATH_CTRL:      prdata = {19'd0, math_ctrl_reg};
            cmws_pkg::ADDR_FIXED_COLOR:    prdata = {17'd0, fixed_color_reg};
            cmws_pkg::ADDR_BRIGHTNESS:     prdata = {28'd0, brightness_reg};
            cmws_pkg::ADDR_FORCED_BLANK:   prdata = {31'd0, forced_blank_reg};
            default:                       prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic in_valid_reg, prod_valid_reg, out_valid_reg;
    logic out_ready, prod_ready, in_ready;

    assign out_ready  = !out_valid_reg || m_axis_tready;
    assign prod_ready = !prod_valid_reg || out_ready;
    assign in_ready   = !in_valid_reg || prod_ready;
    assign s_axis_tready = in_ready;
    assign m_axis_tvalid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (in_ready)   in_valid_reg   <= s_axis_tvalid;
            if (prod_ready) prod_valid_reg <= in_valid_reg;
            if (out_ready)  out_valid_reg  <= prod_valid_reg;
        end
    end

    // ---------------- stage 1: input register ----------------
    cmws_pkg::pix_data_t pix_reg;
    cmws_pkg::pix_user_t src_reg;

    always_ff @(posedge aclk) begin
        if (in_ready && s_axis_tvalid) begin
            pix_reg <= s_axis_tdata[37:0];
            src_reg <= s_axis_tuser;
        end
    end

    // ---------------- window, clip and colour math ----------------
    logic t1, t2, e1, e2, win;
    logic sub_real, math_on, clip_on, halve_eff;
    cmws_pkg::rgb5_t main_c, op_c, mix_c;
    logic [11:0] prod_r_next, prod_g_next, prod_b_next;

    always_comb begin
        e1 = win_ctrl_reg[0];
        e2 = win_ctrl_reg[2];
        t1 = cmws_pkg::in_range(pix_reg.pixel_x, win_bounds_reg[7:0], win_bounds_reg[15:8])
             ^ win_ctrl_reg[1];
        t2 = cmws_pkg::in_range(pix_reg.pixel_x, win_bounds_reg[23:16], win_bounds_reg[31:24])
             ^ win_ctrl_reg[3];
        priority if (e1 && e2) begin
            unique case (win_ctrl_reg[5:4])
                cmws_pkg::COMB_OR:   win = t1 || t2;
                cmws_pkg::COMB_AND:  win = t1 && t2;
                cmws_pkg::COMB_XOR:  win = t1 ^ t2;
                cmws_pkg::COMB_XNOR: win = !(t1 ^ t2);
                default:             win = 1'b0;
            endcase
        end else if (e1) begin
            win = t1;
        end else if (e2) begin
            win = t2;
        end else begin
            win = 1'b0;
        end

        clip_on  = cmws_pkg::mode_hits(math_ctrl_reg.clip_mode, win);
        sub_real = math_ctrl_reg.use_sub && (src_reg.sub_source != cmws_pkg::SRC_BACKDROP);
        // sources six and seven never take part in math
        math_on  = (src_reg.main_source <= cmws_pkg::SRC_LAST_MATH)
                   && math_ctrl_reg.layer_mask[src_reg.main_source]
                   && !cmws_pkg::mode_hits(math_ctrl_reg.prevent_mode, win);
        halve_eff = math_ctrl_reg.half && (sub_real || !math_ctrl_reg.use_sub);

        main_c = clip_on ? '0 : pix_reg.main_color;
        op_c   = sub_real ? pix_reg.sub_color : fixed_color_reg;
        mix_c.red   = cmws_pkg::mix_comp(main_c.red, op_c.red,
                                         math_ctrl_reg.subtract, halve_eff);
        mix_c.green = cmws_pkg::mix_comp(main_c.green, op_c.green,
                                         math_ctrl_reg.subtract, halve_eff);
        mix_c.blue  = cmws_pkg::mix_comp(main_c.blue, op_c.blue,
                                         math_ctrl_reg.subtract, halve_eff);
        if (!math_on) begin
            mix_c = main_c;
        end

        prod_r_next = {4'd0, cmws_pkg::expand5(mix_c.red)} * {8'd0, brightness_reg};
        prod_g_next = {4'd0, cmws_pkg::expand5(mix_c.green)} * {8'd0, brightness_reg};
        prod_b_next = {4'd0, cmws_pkg::expand5(mix_c.blue)} * {8'd0, brightness_reg};
        if (forced_blank_reg) begin
            prod_r_next = '0;
            prod_g_next = '0;
            prod_b_next = '0;
        end
    end

    // ---------------- stage 2: brightness products ----------------
    logic [11:0] prod_r_reg, prod_g_reg, prod_b_reg;

    always_ff @(posedge aclk) begin
        if (prod_ready && in_valid_reg) begin
            prod_r_reg <= prod_r_next;
            prod_g_reg <= prod_g_next;
            prod_b_reg <= prod_b_next;
        end
    end

    // ---------------- stage 3: divide by 15 ----------------
    logic [23:0] quot_r, quot_g, quot_b;
    logic [7:0]  out_r_reg, out_g_reg, out_b_reg;

    assign quot_r = prod_r_reg * cmws_pkg::RECIP_15;
    assign quot_g = prod_g_reg * cmws_pkg::RECIP_15;
    assign quot_b = prod_b_reg * cmws_pkg::RECIP_15;

    always_ff @(posedge aclk) begin
        if (out_ready && prod_valid_reg) begin
            out_r_reg <= quot_r[22:15];
            out_g_reg <= quot_g[22:15];
            out_b_reg <= quot_b[22:15];
        end
    end

    assign m_axis_tdata = {out_b_reg, out_g_reg, out_r_reg};

endmodule

`default_nettype wire

[bench/cmws_pixel_checker.sv]
// Pixel checker for the colour math stage: mirrors register writes, predicts each
// pixel's output colour and compares it with the result stream. Depends on cmws_pkg.
`timescale 1ns / 1ps

module cmws_pixel_checker (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_axis_tvalid,
    input  wire logic                           s_axis_tready,
    input  wire logic [39:0]                    s_axis_tdata,
    input  wire logic [5:0]                     s_axis_tuser,
    input  wire logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    input  wire logic [23:0]                    m_axis_tdata,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic                           pready,
    input  wire logic [cmws_pkg::AddrWidth-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output int unsigned                         mismatch_count,
    output int unsigned                         results_owed
);

    // Shadow copy of the block's registers
    logic [31:0]          bounds_cfg;
    logic [5:0]           win_cfg;
    cmws_pkg::math_ctrl_t math_cfg;
    cmws_pkg::rgb5_t      fixed_cfg;
    logic [3:0]           bright_cfg;
    logic                 blank_cfg;

    logic [23:0] expected_rgb[$];
    logic [23:0] want;
    int unsigned errors = 0;

    function automatic logic window_hit(input logic [7:0] x);
        logic t1;
        logic t2;
        t1 = ((x >= bounds_cfg[7:0]) && (x <= bounds_cfg[15:8])) ^ win_cfg[1];
        t2 = ((x >= bounds_cfg[23:16]) && (x <= bounds_cfg[31:24])) ^ win_cfg[3];
        case ({win_cfg[2], win_cfg[0]})
            2'b00: return 1'b0;
            2'b01: return t1;
            2'b10: return t2;
            default: begin
                case (win_cfg[5:4])
                    cmws_pkg::COMB_OR:  return t1 | t2;
                    cmws_pkg::COMB_AND: return t1 & t2;
                    cmws_pkg::COMB_XOR: return t1 ^ t2;
                    default:            return ~(t1 ^ t2);
                endcase
            end
        endcase
    endfunction

    function automatic logic mode_fires(input logic [1:0] mode, input logic win);
        case (mode)
            cmws_pkg::MODE_NEVER:   return 1'b0;
            cmws_pkg::MODE_OUTSIDE: return !win;
            cmws_pkg::MODE_INSIDE:  return win;
            default:                return 1'b1;
        endcase
    endfunction

    function automatic logic [23:0] shade_pixel(input cmws_pkg::pix_data_t d,
                                                input cmws_pkg::pix_user_t u);
        logic        win;
        logic        sub_real;
        logic        math_on;
        int          chan [3];
        int          subc [3];
        int          fixc [3];
        int          op;
        int          v;
        int          wide;
        logic [23:0] rgb;
        if (blank_cfg)
            return 24'd0;
        chan[0] = int'(d.main_color.red);
        chan[1] = int'(d.main_color.green);
        chan[2] = int'(d.main_color.blue);
        subc[0] = int'(d.sub_color.red);
        subc[1] = int'(d.sub_color.green);
        subc[2] = int'(d.sub_color.blue);
        fixc[0] = int'(fixed_cfg.red);
        fixc[1] = int'(fixed_cfg.green);
        fixc[2] = int'(fixed_cfg.blue);
        win = window_hit(d.pixel_x);
        sub_real = math_cfg.use_sub && (u.sub_source != cmws_pkg::SRC_BACKDROP);
        // sources six and seven never take part in colour math
        math_on = (u.main_source <= cmws_pkg::SRC_LAST_MATH)
                  && math_cfg.layer_mask[(u.main_source <= cmws_pkg::SRC_LAST_MATH)
                                         ? u.main_source : 3'd0]
                  && !mode_fires(math_cfg.prevent_mode, win);
        if (mode_fires(math_cfg.clip_mode, win)) begin
            chan[0] = 0;
            chan[1] = 0;
            chan[2] = 0;
        end
        for (int k = 0; k < 3; k++) begin
            if (math_on) begin
                op = sub_real ? subc[k] : fixc[k];
                v = math_cfg.subtract ? chan[k] - op : chan[k] + op;
                if (v < 0)
                    v = 0;
                // halving is skipped when the sub-screen was wanted but shows backdrop
                if (math_cfg.half && (sub_real || !math_cfg.use_sub))
                    v = v / 2;
                if (v > 31)
                    v = 31;
                chan[k] = v;
            end
            wide = (chan[k] << 3) | (chan[k] >> 2);
            rgb[8*k +: 8] = 8'((wide * int'(bright_cfg)) / 15);
        end
        return rgb;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            bounds_cfg <= '0;
            win_cfg    <= '0;
            math_cfg   <= '0;
            fixed_cfg  <= '0;
            bright_cfg <= 4'd15;
            blank_cfg  <= 1'b1;
            expected_rgb.delete();
            results_owed   <= 0;
            mismatch_count <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_rgb.size() == 0) begin
                    $error("unexpected result 0x%06h with nothing outstanding", m_axis_tdata);
                    errors++;
                end else begin
                    want = expected_rgb.pop_front();
                    for (int k = 0; k < 3; k++) begin
                        if (m_axis_tdata[8*k +: 8] !== want[8*k +: 8]) begin
                            $error("%s: expected %0d, got %0d",
                                   (k == 0) ? "out_red" : (k == 1) ? "out_green" : "out_blue",
                                   want[8*k +: 8], m_axis_tdata[8*k +: 8]);
                            errors++;
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_rgb.push_back(shade_pixel(s_axis_tdata[37:0], s_axis_tuser));
            if (psel && penable && pwrite && pready) begin
                case (paddr)
                    cmws_pkg::ADDR_WINDOW_BOUNDS:  bounds_cfg <= pwdata;
                    cmws_pkg::ADDR_COLOR_WIN_CTRL: win_cfg    <= pwdata[5:0];
                    cmws_pkg::ADDR_MATH_CTRL:      math_cfg   <= pwdata[12:0];
                    cmws_pkg::ADDR_FIXED_COLOR:    fixed_cfg  <= pwdata[14:0];
                    cmws_pkg::ADDR_BRIGHTNESS:     bright_cfg <= pwdata[3:0];
                    cmws_pkg::ADDR_FORCED_BLANK:   blank_cfg  <= pwdata[0];
                    default: ;
                endcase
            end
            results_owed   <= expected_rgb.size();
            mismatch_count <= errors;
        end
    end

endmodule

[bench/color_math_window_stage_core_tb.sv]
// Top of the colour math stage bench: clock, reset, register writes, pixel requests
// and result back-pressure. Depends on cmws_pkg, the core and cmws_pixel_checker.
`timescale 1ns / 1ps

module color_math_window_stage_core_tb;

    localparam int PHASES      = 14;
    localparam int PHASE_ITEMS = 125;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 500000;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [39:0]                    s_axis_tdata = '0;
    logic [5:0]                     s_axis_tuser = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [23:0]                    m_axis_tdata;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [cmws_pkg::AddrWidth-1:0] paddr = '0;
    logic [31:0]                    pwdata = '0;
    logic [31:0]                    prdata;
    logic                           pready;

    int unsigned mismatch_count;
    int unsigned results_owed;
    int          cycle_count = 0;
    logic        calm = 1'b0;
    logic        hold_req = 1'b0;
    logic        hold_done = 1'b0;

    color_math_window_stage_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    cmws_pixel_checker scoreboard (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side: random stall bursts, one long hold-off on request
    initial begin
        int stall;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_done = 1'b1;
            end else if (!calm && $urandom_range(0, 6) == 0) begin
                stall = int'($urandom_range(1, 13));
                m_axis_tready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic reg_write(input logic [cmws_pkg::AddrWidth-1:0] addr,
                             input logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Offers one pixel request, with an occasional idle burst first
    task automatic send_pixel(input logic [7:0] x,
                              input logic [4:0] mr, input logic [4:0] mg,
                              input logic [4:0] mb, input logic [2:0] ms,
                              input logic [4:0] sr, input logic [4:0] sg,
                              input logic [4:0] sb, input logic [2:0] ss);
        cmws_pkg::pix_data_t d;
        cmws_pkg::pix_user_t u;
        int                  gap;
        d.pixel_x          = x;
        d.main_color.red   = mr;
        d.main_color.green = mg;
        d.main_color.blue  = mb;
        d.sub_color.red    = sr;
        d.sub_color.green  = sg;
        d.sub_color.blue   = sb;
        u.main_source      = ms;
        u.sub_source       = ss;
        @(negedge aclk);
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = int'($urandom_range(1, 13));
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, d};
        s_axis_tuser  <= u;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (results_owed != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_all(input logic [31:0] bounds, input logic [5:0] win_ctrl,
                           input cmws_pkg::math_ctrl_t mc, input logic [14:0] fixed,
                           input logic [3:0] bright, input logic blank);
        wait_idle();
        reg_write(cmws_pkg::ADDR_WINDOW_BOUNDS, bounds);
        reg_write(cmws_pkg::ADDR_COLOR_WIN_CTRL, {26'd0, win_ctrl});
        reg_write(cmws_pkg::ADDR_MATH_CTRL, {19'd0, mc});
        reg_write(cmws_pkg::ADDR_FIXED_COLOR, {17'd0, fixed});
        reg_write(cmws_pkg::ADDR_BRIGHTNESS, {28'd0, bright});
        reg_write(cmws_pkg::ADDR_FORCED_BLANK, {31'd0, blank});
    endtask

    // Both windows on, window 2 inverted; one pixel inside window 1, one outside
    task automatic window_pair(input logic [1:0] comb);
        cmws_pkg::math_ctrl_t mc;
        mc = '0;
        mc.layer_mask   = 6'h3F;
        mc.use_sub      = 1'b1;
        mc.clip_mode    = cmws_pkg::MODE_INSIDE;
        mc.prevent_mode = cmws_pkg::MODE_OUTSIDE;
        set_all(32'h28141E0A, {comb, 4'b1101}, mc, 15'h1234, 4'd7, 1'b0);
        send_pixel(8'd25, 5'd20, 5'd20, 5'd20, 3'd0, 5'd5, 5'd9, 5'd13, 3'd1);
        send_pixel(8'd5, 5'd20, 5'd20, 5'd20, 3'd2, 5'd5, 5'd9, 5'd13, 3'd3);
    endtask

    initial begin
        cmws_pkg::math_ctrl_t mc;
        logic [31:0]          bounds;
        logic [7:0]           lo;
        logic [7:0]           hi;
        logic [7:0]           tmp;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: forced blank
        send_pixel(8'd0, 5'd31, 5'd31, 5'd31, 3'd0, 5'd31, 5'd31, 5'd31, 3'd0);
        send_pixel(8'd255, 5'd0, 5'd0, 5'd0, 3'd7, 5'd0, 5'd0, 5'd0, 3'd7);

        // add sub-screen, every layer, no window
        mc = '0;
        mc.layer_mask = 6'h3F;
        mc.use_sub    = 1'b1;
        set_all(32'h28141E0A, 6'd0, mc, 15'h7FFF, 4'd15, 1'b0);
        send_pixel(8'd0, 5'd31, 5'd31, 5'd31, 3'd0, 5'd31, 5'd31, 5'd31, 3'd0);
        send_pixel(8'd128, 5'd0, 5'd0, 5'd0, 3'd4, 5'd0, 5'd0, 5'd0, 3'd1);
        send_pixel(8'd255, 5'd1, 5'd2, 5'd3, 3'd5, 5'd4, 5'd5, 5'd6,
                   cmws_pkg::SRC_BACKDROP);
        send_pixel(8'd64, 5'd10, 5'd20, 5'd30, 3'd6, 5'd5, 5'd5, 5'd5, 3'd2);
        send_pixel(8'd65, 5'd10, 5'd20, 5'd30, 3'd7, 5'd5, 5'd5, 5'd5, 3'd3);

        // subtract with halve; underflow, plain halve, backdrop operand without halve
        mc.subtract = 1'b1;
        mc.half     = 1'b1;
        set_all(32'h28141E0A, 6'd0, mc, 15'h4210, 4'd15, 1'b0);
        send_pixel(8'd1, 5'd0, 5'd0, 5'd0, 3'd0, 5'd31, 5'd31, 5'd31, 3'd0);
        send_pixel(8'd2, 5'd31, 5'd31, 5'd31, 3'd1, 5'd0, 5'd0, 5'd0, 3'd2);
        send_pixel(8'd3, 5'd31, 5'd20, 5'd8, 3'd2, 5'd0, 5'd0, 5'd0,
                   cmws_pkg::SRC_BACKDROP);

        // fixed colour operand, halved add
        mc.subtract = 1'b0;
        mc.use_sub  = 1'b0;
        set_all(32'h28141E0A, 6'd0, mc, 15'h7FFF, 4'd15, 1'b0);
        send_pixel(8'd4, 5'd31, 5'd31, 5'd31, 3'd3, 5'd0, 5'd0, 5'd0, 3'd0);

        window_pair(cmws_pkg::COMB_OR);
        window_pair(cmws_pkg::COMB_AND);
        window_pair(cmws_pkg::COMB_XOR);
        window_pair(cmws_pkg::COMB_XNOR);

        // empty window 1 (left above right), plain then inverted
        mc = '0;
        mc.clip_mode = cmws_pkg::MODE_OUTSIDE;
        set_all(32'h000064C8, 6'b000001, mc, 15'h0, 4'd15, 1'b0);
        send_pixel(8'd150, 5'd17, 5'd9, 5'd3, 3'd0, 5'd1, 5'd1, 5'd1, 3'd0);
        set_all(32'h000064C8, 6'b000011, mc, 15'h0, 4'd15, 1'b0);
        send_pixel(8'd150, 5'd17, 5'd9, 5'd3, 3'd0, 5'd1, 5'd1, 5'd1, 3'd0);

        for (int phase = 0; phase < PHASES; phase++) begin
            calm = (phase >= PHASES - 2);
            if (phase == 0) begin
                set_all(32'hFFFFFFFF, 6'h3F, 13'h1FFF, 15'h7FFF, 4'd15, 1'b0);
            end else if (phase == 1) begin
                set_all(32'h0, 6'h0, 13'h0, 15'h0, 4'd0, 1'b0);
            end else begin
                bounds = '0;
                for (int w = 0; w < 2; w++) begin
                    lo = 8'($urandom_range(0, 255));
                    hi = 8'($urandom_range(0, 255));
                    // mostly proper ranges, sometimes empty ones
                    if (lo > hi && $urandom_range(0, 4) != 0) begin
                        tmp = lo;
                        lo  = hi;
                        hi  = tmp;
                    end
                    bounds[16*w +: 8]     = lo;
                    bounds[16*w + 8 +: 8] = hi;
                end
                mc = 13'($urandom_range(0, 8191));
                if ($urandom_range(0, 2) != 0)
                    mc.prevent_mode = cmws_pkg::MODE_NEVER;
                if ($urandom_range(0, 2) != 0)
                    mc.clip_mode = cmws_pkg::MODE_NEVER;
                set_all(bounds, 6'($urandom_range(0, 63)), mc, 15'($urandom_range(0, 32767)),
                        4'($urandom_range(0, 15)), $urandom_range(0, 9) == 0);
            end
            if (phase == 4)
                hold_req = 1'b1;
            repeat (PHASE_ITEMS)
                send_pixel(8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                           5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                           3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)),
                           5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                           3'($urandom_range(0, 7)));
        end

        wait_idle();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0 && results_owed == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[sim.f]
src/cmws_pkg.sv
src/color_math_window_stage_core.sv
bench/cmws_pixel_checker.sv
bench/color_math_window_stage_core_tb.sv
